@@ src/tsg_pkg.sv @@
`default_nettype none

package tsg_pkg;

  // Timestamp and epoch width, also the widest configuration register.
  localparam int NowW     = 63;
  localparam int CfgW     = 63;
  localparam int CfgIdxW  = 3;

  // Register field widths.
  localparam int CountW   = 8;
  localparam int MsW      = 16;

  // Default nanoseconds per millisecond.
  localparam int NsPerMsDef = 1000000;

  // Restoring division, one quotient bit per cycle over the timestamp.
  localparam int DivCntW  = $clog2(NowW);

  typedef enum logic [CfgIdxW-1:0] {
    RegPhaseCount = 3'd0,
    RegPhaseIndex = 3'd1,
    RegOnTime     = 3'd2,
    RegGuardTime  = 3'd3,
    RegEpoch      = 3'd4
  } tsg_reg_e;

  typedef struct packed {
    logic load;      // capture the item
    logic mul_slot;  // slot and on-time lengths in ns
    logic mul_per;   // period, slot start, early-off check
    logic div_step;  // one step of the modulo
    logic commit;    // decide and load the result register
  } tsg_cmd_t;

endpackage

`default_nettype wire

@@ src/tdm_slot_gate.sv @@
// Time-division slot gate for one device sharing a time base with others.
// Input channel (in_valid_i/in_ready_o): kind_i 0 is a tick carrying now_ns_i,
// kind_i 1 is a stop that forces the device off. Each item gives exactly one
// result on the output channel (out_valid_o/out_ready_i): device_on_o is the
// device state after the item, switched_o flags a change of that state.
// Configuration: write cfg_wdata_i to register cfg_addr_i when cfg_we_i is
// high (0 phase count, 1 phase index, 2 on time ms, 3 guard time ms,
// 4 epoch ns); write only while the block is idle.
// Each item passes a slot multiply, a period multiply, a restoring modulo
// of the epoch-relative time by the period at one bit per cycle, which sets
// the rate, and a commit. One item is in flight at a time; the next is
// taken the cycle after the result lands in the output register.
// A stalled receiver holds the result register; a finished item then waits
// until that register frees up, and no new item is taken meanwhile.
// Reset: phase count 1, other config 0, device off, no result pending.
`default_nettype none

module tdm_slot_gate import tsg_pkg::*; #(
  parameter int NS_PER_MS = NsPerMsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_addr_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [NowW-1:0]    now_ns_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    device_on_o,
  output logic                    switched_o
);

  tsg_cmd_t cmd;

  // Sequence each item: capture, multiply, divide, commit.
  tsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold configuration, slot arithmetic, modulo and the device state.
  tsg_dp #(
    .NS_PER_MS (NS_PER_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind_i),
    .now_ns_i    (now_ns_i),
    .cmd_i       (cmd),
    .device_on_o (device_on_o),
    .switched_o  (switched_o)
  );

endmodule

`default_nettype wire

@@ src/tsg_ctrl.sv @@
`default_nettype none

module tsg_ctrl import tsg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output tsg_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMulSlot,
    StMulPer,
    StDiv,
    StDone
  } state_e;

  state_e             state_q;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  logic               slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.mul_slot = (state_q == StMulSlot);
    cmd_o.mul_per  = (state_q == StMulPer);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.commit   = (state_q == StDone) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StDone) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StMulSlot;
          end
        end
        StMulSlot: begin
          state_q <= StMulPer;
        end
        StMulPer: begin
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(NowW - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          // Hold until the result register can take the item.
          if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/tsg_dp.sv @@
`default_nettype none

module tsg_dp import tsg_pkg::*; #(
  parameter int NS_PER_MS = NsPerMsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_addr_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               kind_i,
  input  wire logic [NowW-1:0]    now_ns_i,
  input  wire tsg_cmd_t           cmd_i,
  output logic                    device_on_o,
  output logic                    switched_o
);

  localparam int NsW    = $clog2(NS_PER_MS + 1);
  localparam int SlotMW = MsW + 1;
  localparam int SlotW  = SlotMW + NsW;
  localparam int OnW    = MsW + NsW;
  localparam int PerW   = SlotW + CountW;
  localparam logic [NsW-1:0] NsPerMs = NsW'(NS_PER_MS);

  // Configuration registers.
  logic [CountW-1:0] pc_q;
  logic [CountW-1:0] pi_q;
  logic [MsW-1:0]    on_ms_q;
  logic [MsW-1:0]    guard_q;
  logic [NowW-1:0]   epoch_q;

  // Working registers.
  logic              kind_q;
  logic [NowW-1:0]   t_q;
  logic [SlotW-1:0]  slot_ns_q;
  logic [OnW-1:0]    on_ns_q;
  logic [PerW-1:0]   period_q;
  logic [PerW-1:0]   start_q;
  logic              early_q;
  logic [PerW-1:0]   rem_q;
  logic              dev_q;
  logic              sw_q;

  logic [SlotMW-1:0] slot_ms;
  logic [NowW:0]     diff;
  logic [PerW:0]     trial;
  logic              trial_ge;
  logic [PerW:0]     offs;
  logic              want_on;

  assign slot_ms  = {1'b0, on_ms_q} + {1'b0, guard_q};
  assign diff     = {1'b0, t_q} - {1'b0, epoch_q};
  assign trial    = {rem_q, t_q[NowW-1]};
  assign trial_ge = (trial >= {1'b0, period_q});
  assign offs     = {1'b0, rem_q} - {1'b0, start_q};
  assign want_on  = !early_q && !offs[PerW] && (offs[PerW-1:0] < PerW'(on_ns_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= CountW'(1);
      pi_q       <= '0;
      on_ms_q    <= '0;
      guard_q    <= '0;
      epoch_q    <= '0;
      dev_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (tsg_reg_e'(cfg_addr_i))
          RegPhaseCount: pc_q       <= cfg_wdata_i[CountW-1:0];
          RegPhaseIndex: pi_q       <= cfg_wdata_i[CountW-1:0];
          RegOnTime:     on_ms_q    <= cfg_wdata_i[MsW-1:0];
          RegGuardTime:  guard_q    <= cfg_wdata_i[MsW-1:0];
          RegEpoch:      epoch_q    <= cfg_wdata_i[NowW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.commit) begin
        dev_q <= want_on;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      t_q    <= now_ns_i;
    end
    if (cmd_i.mul_slot) begin
      slot_ns_q <= SlotW'(slot_ms) * SlotW'(NsPerMs);
      on_ns_q   <= OnW'(on_ms_q) * OnW'(NsPerMs);
    end
    if (cmd_i.mul_per) begin
      period_q <= PerW'(pc_q) * PerW'(slot_ns_q);
      start_q  <= PerW'(pi_q) * PerW'(slot_ns_q);
      // Zero slot length or zero count means zero period.
      early_q  <= kind_q || (pc_q == '0) || (slot_ms == '0) || diff[NowW];
      t_q      <= diff[NowW-1:0];
      rem_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? PerW'(trial - {1'b0, period_q}) : trial[PerW-1:0];
      t_q   <= {t_q[NowW-2:0], 1'b0};
    end
    if (cmd_i.commit) begin
      sw_q <= want_on ^ dev_q;
    end
  end

  assign device_on_o = dev_q;
  assign switched_o  = sw_q;

endmodule

`default_nettype wire
